@@ design/spk_pkg.sv @@
// Shared types, codes and the control store for the spiral element reader.
// No dependencies; imported by the top level and the checker.
package spk_pkg;

  // Fixed field widths
  localparam int CNT_W      = 5;          // row/column counts and bounds
  localparam int POS_W      = 9;          // spiral position
  localparam int ELEM_W     = 32;         // element and load value
  localparam int IDX_W      = 4;          // load row / load column
  localparam int PROD_W     = 2 * CNT_W;  // rows * cols
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Register indexes
  localparam cfg_idx_t REG_ROW_COUNT = 2'd0;
  localparam cfg_idx_t REG_COL_COUNT = 2'd1;

  localparam logic [CNT_W-1:0] ROW_COUNT_RST = 5'd16;
  localparam logic [CNT_W-1:0] COL_COUNT_RST = 5'd16;

  // Item opcodes
  localparam logic ITEM_LOAD  = 1'b0;
  localparam logic ITEM_QUERY = 1'b1;

  // Step addresses of the control program
  typedef logic [2:0] pc_t;
  localparam pc_t PC_IDLE  = 3'd0;
  localparam pc_t PC_RING  = 3'd1;
  localparam pc_t PC_TOP   = 3'd2;
  localparam pc_t PC_RIGHT = 3'd3;
  localparam pc_t PC_BOT   = 3'd4;
  localparam pc_t PC_LEFT  = 3'd5;
  localparam pc_t PC_READ  = 3'd6;
  localparam pc_t PC_MISS  = 3'd7;

  typedef enum logic [2:0] {
    UOP_WAIT,   // take the next item
    UOP_RING,   // check ring, skip it whole if the position lies beyond it
    UOP_SIDE,   // walk one side of the current ring
    UOP_READ,   // deliver the element read from the store
    UOP_MISS    // deliver a not-found result
  } uop_t;

  typedef enum logic [1:0] {
    SIDE_TOP,
    SIDE_RIGHT,
    SIDE_BOT,
    SIDE_LEFT
  } side_t;

  typedef enum logic [1:0] {
    GRD_NONE,   // always walk
    GRD_TB,     // walk only while top < bottom
    GRD_LR      // walk only while left < right
  } guard_t;

  typedef struct packed {
    uop_t   uop;
    side_t  side;
    guard_t guard;
    pc_t    jmp;
  } ctrl_t;

  // Control store: one word per step
  function automatic ctrl_t ucode(pc_t pc);
    ctrl_t w;
    w = '{uop: UOP_WAIT, side: SIDE_TOP, guard: GRD_NONE, jmp: PC_IDLE};
    unique case (pc)
      PC_IDLE:  w = '{uop: UOP_WAIT, side: SIDE_TOP,   guard: GRD_NONE, jmp: PC_IDLE};
      PC_RING:  w = '{uop: UOP_RING, side: SIDE_TOP,   guard: GRD_NONE, jmp: PC_TOP};
      PC_TOP:   w = '{uop: UOP_SIDE, side: SIDE_TOP,   guard: GRD_NONE, jmp: PC_RIGHT};
      PC_RIGHT: w = '{uop: UOP_SIDE, side: SIDE_RIGHT, guard: GRD_NONE, jmp: PC_BOT};
      PC_BOT:   w = '{uop: UOP_SIDE, side: SIDE_BOT,   guard: GRD_TB,   jmp: PC_LEFT};
      PC_LEFT:  w = '{uop: UOP_SIDE, side: SIDE_LEFT,  guard: GRD_LR,   jmp: PC_RING};
      PC_READ:  w = '{uop: UOP_READ, side: SIDE_TOP,   guard: GRD_NONE, jmp: PC_IDLE};
      PC_MISS:  w = '{uop: UOP_MISS, side: SIDE_TOP,   guard: GRD_NONE, jmp: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ design/spk_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port: hold the last word until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/spiral_kth_element.sv @@
// Top level of the spiral element reader: matrix store and query sequencer.
// Depends on spk_pkg and spk_ram.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------------------
//  in_     | input     | in_valid / in_stall | opcode, load_row, load_col, load_value, position
//  out_    | output    | out_valid/out_stall | element, found
//  cfg_    | input     | cfg_valid/cfg_ready | index, data
//
// A load item gives no result and leaves the input free. A query in range passes
// through S ring skips by the ring loop of the sequencer, W side steps (at most four)
// and one read of the store. A query out of range goes straight to its not-found
// result.
// One item is in work at a time; a finished result waits in the output register
// while the next item is taken. Reset is synchronous and clears control only.
// A stalled output holds the query in its delivery step until the result is taken.
module spiral_kth_element
  import spk_pkg::*;
#(
  parameter int MAX_ROWS   = 16,
  parameter int MAX_COLS   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_opcode,
  input  logic [IDX_W-1:0]         in_load_row,
  input  logic [IDX_W-1:0]         in_load_col,
  input  logic signed [ELEM_W-1:0] in_load_value,
  input  logic [POS_W-1:0]         in_position,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [ELEM_W-1:0] out_element,
  output logic                     out_found,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  cfg_idx_t                 cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AF_W   = CNT_W + $clog2(MAX_COLS) + 1;

  // Control registers
  pc_t               pc_r, pc_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]  row_count_r, row_count_nxt;
  logic [CNT_W-1:0]  col_count_r, col_count_nxt;

  // Datapath registers
  logic [POS_W-1:0]         kk_r, kk_nxt;
  logic [CNT_W-1:0]         top_r, top_nxt, bot_r, bot_nxt;
  logic [CNT_W-1:0]         left_r, left_nxt, right_r, right_nxt;
  logic signed [ELEM_W-1:0] out_element_r, out_element_nxt;
  logic                     out_found_r, out_found_nxt;

  ctrl_t             cw;
  logic              in_acc, out_free;
  logic [CNT_W-1:0]  rows_use, cols_use;
  logic [PROD_W-1:0] q_total;
  logic              q_in_range;
  logic [CNT_W-1:0]  ring_h, ring_w;
  logic              ring_ok, ring_full, ring_skip;
  logic [POS_W-1:0]  ring_per;
  logic              guard_ok, side_hit;
  logic [CNT_W-1:0]  side_len, kk_lo, hit_row, hit_col;
  logic [AF_W-1:0]   rd_addr_full, wr_addr_full;
  logic              ram_we, ram_re;
  logic [DATA_WIDTH-1:0] ram_rdata;

  assign cw        = ucode(pc_r);
  assign in_stall  = (pc_r != PC_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // Saturate sizes to the store
  assign rows_use = (int'(row_count_r) > MAX_ROWS) ? CNT_W'(MAX_ROWS) : row_count_r;
  assign cols_use = (int'(col_count_r) > MAX_COLS) ? CNT_W'(MAX_COLS) : col_count_r;

  // Range check of a new query
  assign q_total    = PROD_W'(rows_use) * PROD_W'(cols_use);
  assign q_in_range = (in_position != '0) && (PROD_W'(in_position) <= q_total);

  // Ring geometry: skip a full ring when the position lies beyond it
  assign ring_ok   = (top_r < bot_r) && (left_r < right_r);
  assign ring_h    = bot_r - top_r;
  assign ring_w    = right_r - left_r;
  assign ring_full = (ring_h >= CNT_W'(2)) && (ring_w >= CNT_W'(2));
  assign ring_per  = ((POS_W'(ring_h) + POS_W'(ring_w)) << 1) - POS_W'(4);
  assign ring_skip = ring_full && (kk_r > ring_per);

  // Side walk: length, guard and the hit coordinates
  assign kk_lo = kk_r[CNT_W-1:0];

  always_comb begin
    unique case (cw.guard)
      GRD_NONE: guard_ok = 1'b1;
      GRD_TB:   guard_ok = (top_r < bot_r);
      GRD_LR:   guard_ok = (left_r < right_r);
      default:  guard_ok = 1'b0;
    endcase
  end

  always_comb begin
    unique case (cw.side)
      SIDE_TOP: begin
        side_len = right_r - left_r;
        hit_row  = top_r;
        hit_col  = left_r + kk_lo - CNT_W'(1);
      end
      SIDE_RIGHT: begin
        side_len = bot_r - top_r;
        hit_row  = top_r + kk_lo - CNT_W'(1);
        hit_col  = right_r - CNT_W'(1);
      end
      SIDE_BOT: begin
        side_len = right_r - left_r;
        hit_row  = bot_r - CNT_W'(1);
        hit_col  = right_r - kk_lo;
      end
      SIDE_LEFT: begin
        side_len = bot_r - top_r;
        hit_row  = bot_r - kk_lo;
        hit_col  = left_r;
      end
    endcase
  end

  assign side_hit = guard_ok && (kk_r <= POS_W'(side_len));

  // Store addressing
  assign rd_addr_full = AF_W'(hit_row) * AF_W'(MAX_COLS) + AF_W'(hit_col);
  assign wr_addr_full = AF_W'(in_load_row) * AF_W'(MAX_COLS) + AF_W'(in_load_col);
  assign ram_re = (cw.uop == UOP_SIDE) && side_hit;
  assign ram_we = in_acc && (in_opcode == ITEM_LOAD)
                  && (int'(in_load_row) < MAX_ROWS) && (int'(in_load_col) < MAX_COLS);

  spk_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr_full[ADDR_W-1:0]),
    .wdata (DATA_WIDTH'($unsigned(in_load_value))),
    .re    (ram_re),
    .raddr (rd_addr_full[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Sequencer: next step, datapath and output register
  always_comb begin
    pc_nxt          = pc_r;
    kk_nxt          = kk_r;
    top_nxt         = top_r;
    bot_nxt         = bot_r;
    left_nxt        = left_r;
    right_nxt       = right_r;
    out_valid_nxt   = out_valid_r;
    out_element_nxt = out_element_r;
    out_found_nxt   = out_found_r;

    // drop a result once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (cw.uop)
      UOP_WAIT: begin
        if (in_acc && (in_opcode == ITEM_QUERY)) begin
          if (q_in_range) begin
            pc_nxt    = PC_RING;
            kk_nxt    = in_position;
            top_nxt   = '0;
            left_nxt  = '0;
            bot_nxt   = rows_use;
            right_nxt = cols_use;
          end else begin
            pc_nxt = PC_MISS;
          end
        end
      end
      UOP_RING: begin
        if (!ring_ok) begin
          pc_nxt = PC_MISS;
        end else if (ring_skip) begin
          kk_nxt    = kk_r - ring_per;
          top_nxt   = top_r + CNT_W'(1);
          left_nxt  = left_r + CNT_W'(1);
          bot_nxt   = bot_r - CNT_W'(1);
          right_nxt = right_r - CNT_W'(1);
        end else begin
          pc_nxt = cw.jmp;
        end
      end
      UOP_SIDE: begin
        if (side_hit) begin
          pc_nxt = PC_READ;
        end else begin
          pc_nxt = cw.jmp;
          if (guard_ok) begin
            kk_nxt = kk_r - POS_W'(side_len);
            unique case (cw.side)
              SIDE_TOP:   top_nxt   = top_r + CNT_W'(1);
              SIDE_RIGHT: right_nxt = right_r - CNT_W'(1);
              SIDE_BOT:   bot_nxt   = bot_r - CNT_W'(1);
              SIDE_LEFT:  left_nxt  = left_r + CNT_W'(1);
            endcase
          end
        end
      end
      UOP_READ: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_element_nxt = ELEM_W'(ram_rdata);
          out_found_nxt   = 1'b1;
          pc_nxt          = PC_IDLE;
        end
      end
      UOP_MISS: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_element_nxt = '0;
          out_found_nxt   = 1'b0;
          pc_nxt          = PC_IDLE;
        end
      end
      default: begin
        pc_nxt = PC_IDLE;
      end
    endcase
  end

  // Configuration writes
  always_comb begin
    row_count_nxt = row_count_r;
    col_count_nxt = col_count_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROW_COUNT: row_count_nxt = cfg_data;
        REG_COL_COUNT: col_count_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_IDLE;
      out_valid_r <= 1'b0;
      row_count_r <= ROW_COUNT_RST;
      col_count_r <= COL_COUNT_RST;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      row_count_r <= row_count_nxt;
      col_count_r <= col_count_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    kk_r          <= kk_nxt;
    top_r         <= top_nxt;
    bot_r         <= bot_nxt;
    left_r        <= left_nxt;
    right_r       <= right_nxt;
    out_element_r <= out_element_nxt;
    out_found_r   <= out_found_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_element = out_element_r;
  assign out_found   = out_found_r;

endmodule

@@ design/spk_checker.sv @@
// Port-level checks for the spiral element reader, bound to the top level.
// Depends on spk_pkg and spiral_kth_element.
module spk_checker
  import spk_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     in_opcode,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [ELEM_W-1:0] out_element,
  input logic                     out_found
);

  // Reset leaves the block empty and ready
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // A miss carries a zero element
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_element == '0)
    else $error("not-found result with non-zero element");

  // A waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_element) && $stable(out_found))
    else $error("stalled result changed");

  // A load finishes at once
  a_load_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_opcode == ITEM_LOAD |=> !in_stall)
    else $error("load item held the input");

  // A query occupies the sequencer
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_opcode == ITEM_QUERY |=> in_stall)
    else $error("query item did not start the sequencer");

endmodule

bind spiral_kth_element spk_checker u_spk_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_opcode   (in_opcode),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_element (out_element),
  .out_found   (out_found)
);

@@ tb/tb_spiral_kth_element.sv @@
// Self-checking testbench for spiral_kth_element: loads and spiral queries under
// random idling and stalls, predicted by an in-bench spiral walk. Depends on spk_pkg.
module tb_spiral_kth_element
  import spk_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIM      = 16;
  localparam int PHASE_ITEMS  = 75;
  localparam int SMALL_AREA   = 64;
  localparam int DRAIN_CYCLES = 30;
  localparam int STALL_LIMIT  = 2000;

  // Register indexes that map to no register
  localparam cfg_idx_t REG_SPARE_2 = 2'd2;
  localparam cfg_idx_t REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic              opcode;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [ELEM_W-1:0] value;
    logic [POS_W-1:0]  pos;
  } item_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] element;
    logic                     found;
  } answer_t;

  typedef struct packed {
    item_t   it;
    logic    typed;
    answer_t ans;
  } probe_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_opcode;
  logic [IDX_W-1:0] in_load_row;
  logic [IDX_W-1:0] in_load_col;
  logic signed [ELEM_W-1:0] in_load_value;
  logic [POS_W-1:0] in_position;
  logic out_valid;
  logic out_stall;
  logic signed [ELEM_W-1:0] out_element;
  logic out_found;
  logic cfg_valid;
  logic cfg_ready;
  cfg_idx_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Mirror of the block's state
  logic [ELEM_W-1:0] matrix_mirror [MAX_DIM*MAX_DIM];
  bit                cell_written [MAX_DIM*MAX_DIM];
  logic [CNT_W-1:0]  row_reg;
  logic [CNT_W-1:0]  col_reg;

  answer_t    pending_answers[$];
  probe_row_t probe_rows[$];
  int         fail_count = 0;
  int         quiet_cycles = 0;
  bit         no_idle = 1'b0;

  spiral_kth_element dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_load_row   (in_load_row),
    .in_load_col   (in_load_col),
    .in_load_value (in_load_value),
    .in_position   (in_position),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_element   (out_element),
    .out_found     (out_found),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Clamp a size register to the store's dimension
  function automatic int clamp_count(input logic [CNT_W-1:0] v);
    return (v > MAX_DIM) ? MAX_DIM : int'(v);
  endfunction

  // Walk the clockwise spiral ring by ring until position k is reached
  function automatic bit spiral_cell(input int rows, input int cols, input int k,
                                     output int r, output int c);
    int top, bot, left, right, cnt, i;
    top = 0;
    bot = rows;
    left = 0;
    right = cols;
    cnt = 0;
    r = 0;
    c = 0;
    if (k < 1 || k > rows * cols) return 1'b0;
    while (top < bot && left < right) begin
      for (i = left; i < right; i++) begin
        cnt++;
        if (cnt == k) begin
          r = top; c = i; return 1'b1;
        end
      end
      top++;
      for (i = top; i < bot; i++) begin
        cnt++;
        if (cnt == k) begin
          r = i; c = right - 1; return 1'b1;
        end
      end
      right--;
      if (top < bot) begin
        for (i = right - 1; i >= left; i--) begin
          cnt++;
          if (cnt == k) begin
            r = bot - 1; c = i; return 1'b1;
          end
        end
        bot--;
      end
      if (left < right) begin
        for (i = bot - 1; i >= top; i--) begin
          cnt++;
          if (cnt == k) begin
            r = i; c = left; return 1'b1;
          end
        end
        left++;
      end
    end
    return 1'b0;
  endfunction

  function automatic answer_t spiral_answer(input int k);
    answer_t a;
    int r, c;
    a = '0;
    if (spiral_cell(clamp_count(row_reg), clamp_count(col_reg), k, r, c)) begin
      a.element = matrix_mirror[r*MAX_DIM + c];
      a.found   = 1'b1;
    end
    return a;
  endfunction

  // Unused payload fields carry random values
  function automatic item_t make_load(input int r, input int c, input logic [ELEM_W-1:0] v);
    item_t it;
    it.opcode = ITEM_LOAD;
    it.row    = IDX_W'(r);
    it.col    = IDX_W'(c);
    it.value  = v;
    it.pos    = POS_W'($urandom_range(0, 511));
    return it;
  endfunction

  function automatic item_t make_query(input int k);
    item_t it;
    it.opcode = ITEM_QUERY;
    it.row    = IDX_W'($urandom_range(0, 15));
    it.col    = IDX_W'($urandom_range(0, 15));
    it.value  = $urandom;
    it.pos    = POS_W'(k);
    return it;
  endfunction

  task automatic add_row(input item_t it, input bit typed,
                         input logic signed [ELEM_W-1:0] el, input logic fnd);
    probe_row_t p;
    p.it  = it;
    p.typed = typed;
    p.ans.element = el;
    p.ans.found   = fnd;
    probe_rows = {probe_rows, p};
  endtask

  // Offer one item, hold it until taken, then record its effect
  task automatic send_item(input item_t it, input bit typed, input answer_t typed_ans);
    int gap;
    answer_t ans;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_opcode     = it.opcode;
    in_load_row   = it.row;
    in_load_col   = it.col;
    in_load_value = it.value;
    in_position   = it.pos;
    in_valid      = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (it.opcode == ITEM_LOAD) begin
      matrix_mirror[int'(it.row)*MAX_DIM + int'(it.col)] = it.value;
      cell_written[int'(it.row)*MAX_DIM + int'(it.col)]  = 1'b1;
    end else begin
      ans = typed ? typed_ans : spiral_answer(int'(it.pos));
      pending_answers = {pending_answers, ans};
    end
    @(negedge clk);
  endtask

  // Drop valid, wait for every answer, then let a trailing load finish
  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_size_reg(input cfg_idx_t idx, input logic [CNT_W-1:0] val);
    @(negedge clk);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_ROW_COUNT: row_reg = val;
      REG_COL_COUNT: col_reg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // One size setting: fill and read back small matrices, then mixed traffic
  task automatic run_phase(input logic [CNT_W-1:0] rows_v, input logic [CNT_W-1:0] cols_v,
                           input bit quiet_v);
    int n, sent, pick, k, r, c, rr, cc;
    item_t it;
    set_size_reg(REG_ROW_COUNT, rows_v);
    set_size_reg(REG_COL_COUNT, cols_v);
    no_idle = quiet_v;
    rr = clamp_count(row_reg);
    cc = clamp_count(col_reg);
    n = rr * cc;
    sent = 0;
    if (n > 0 && n <= SMALL_AREA) begin
      for (r = 0; r < rr; r++) begin
        for (c = 0; c < cc; c++) begin
          send_item(make_load(r, c, $urandom), 1'b0, '0);
          sent++;
        end
      end
      for (k = 1; k <= n; k++) begin
        send_item(make_query(k), 1'b0, '0);
        sent++;
      end
    end
    while (sent < PHASE_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        if (n > 0 && $urandom_range(0, 4) != 0)
          it = make_load($urandom_range(0, rr - 1), $urandom_range(0, cc - 1), $urandom);
        else
          it = make_load($urandom_range(0, 15), $urandom_range(0, 15), $urandom);
      end else if (pick < 90 && n > 0) begin
        // load an unwritten cell instead of reading it
        k = $urandom_range(1, n);
        void'(spiral_cell(rr, cc, k, r, c));
        if (cell_written[r*MAX_DIM + c]) it = make_query(k);
        else it = make_load(r, c, $urandom);
      end else begin
        k = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(n + 1, 511);
        it = make_query(k);
      end
      send_item(it, 1'b0, '0);
      sent++;
    end
    wait_idle();
  endtask

  // Result side: stall for a drawn number of cycles before each result
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 7);
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!(rst_n === 1'b1 && out_valid === 1'b1));
      @(negedge clk);
    end
  end

  // Compare each taken result with the oldest expected answer
  always @(posedge clk) begin
    answer_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual element=%0d found=%0b",
                 $time, out_element, out_found);
        fail_count++;
      end else begin
        want = pending_answers.pop_front();
        if (out_element !== want.element) begin
          $display("%0t: element mismatch, expected %0d, actual %0d",
                   $time, want.element, out_element);
          fail_count++;
        end
        if (out_found !== want.found) begin
          $display("%0t: found mismatch, expected %0b, actual %0b",
                   $time, want.found, out_found);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: count cycles in which no handshake completes
  always @(posedge clk) begin
    if (rst_n !== 1'b1) begin
      quiet_cycles <= 0;
    end else if ((in_valid === 1'b1 && in_stall === 1'b0) ||
                 (out_valid === 1'b1 && out_stall === 1'b0) ||
                 (cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int i;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = ITEM_LOAD;
    in_load_row   = '0;
    in_load_col   = '0;
    in_load_value = '0;
    in_position   = '0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_ROW_COUNT;
    cfg_data      = '0;
    row_reg       = ROW_COUNT_RST;
    col_reg       = COL_COUNT_RST;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed part at the reset size: corners, value extremes, range edges
    add_row(make_load(0, 0, 32'h7FFF_FFFF), 1'b0, '0, 1'b0);
    add_row(make_load(0, 15, 32'h8000_0000), 1'b0, '0, 1'b0);
    add_row(make_load(15, 15, 32'hFFFF_FFFF), 1'b0, '0, 1'b0);
    add_row(make_load(15, 0, 32'h0000_0000), 1'b0, '0, 1'b0);
    add_row(make_load(8, 7, 32'h1234_5678), 1'b0, '0, 1'b0);
    add_row(make_query(1), 1'b1, 32'h7FFF_FFFF, 1'b1);
    add_row(make_query(16), 1'b1, 32'h8000_0000, 1'b1);
    add_row(make_query(31), 1'b1, 32'hFFFF_FFFF, 1'b1);
    add_row(make_query(46), 1'b1, 32'h0000_0000, 1'b1);
    add_row(make_query(256), 1'b0, '0, 1'b0);
    add_row(make_query(0), 1'b1, 32'h0000_0000, 1'b0);
    add_row(make_query(257), 1'b1, 32'h0000_0000, 1'b0);
    add_row(make_query(511), 1'b1, 32'h0000_0000, 1'b0);
    add_row(make_load(15, 15, 32'h5A5A_5A5A), 1'b0, '0, 1'b0);
    add_row(make_query(31), 1'b0, '0, 1'b0);
    add_row(make_load(0, 1, 32'h0000_0001), 1'b0, '0, 1'b0);
    add_row(make_query(2), 1'b1, 32'h0000_0001, 1'b1);
    add_row(make_load(1, 0, 32'hFFFF_0000), 1'b0, '0, 1'b0);
    add_row(make_query(60), 1'b0, '0, 1'b0);
    add_row(make_load(1, 1, 32'hA5A5_A5A5), 1'b0, '0, 1'b0);
    add_row(make_query(61), 1'b0, '0, 1'b0);
    add_row(make_query(1), 1'b0, '0, 1'b0);
    for (i = 0; i < probe_rows.size(); i++)
      send_item(probe_rows[i].it, probe_rows[i].typed, probe_rows[i].ans);
    wait_idle();

    // Random part over a sweep of sizes, saturating and empty ones included
    run_phase(5'd1, 5'd1, 1'b0);
    run_phase(5'd1, 5'd16, 1'b0);
    run_phase(5'd16, 5'd1, 1'b1);
    run_phase(5'd0, 5'd7, 1'b0);
    run_phase(5'd9, 5'd0, 1'b0);
    run_phase(5'd31, 5'd31, 1'b1);
    run_phase(5'd17, 5'd4, 1'b0);
    set_size_reg(REG_SPARE_2, CNT_W'($urandom_range(0, 31)));
    set_size_reg(REG_SPARE_3, CNT_W'($urandom_range(0, 31)));
    run_phase(5'd3, 5'd5, 1'b0);
    run_phase(5'd6, 5'd6, 1'b1);
    run_phase(5'd2, 5'd9, 1'b0);
    run_phase(5'd16, 5'd16, 1'b0);

    if (fail_count == 0 && pending_answers.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/spk_pkg.sv
design/spk_ram.sv
design/spiral_kth_element.sv
design/spk_checker.sv
tb/tb_spiral_kth_element.sv
